// File: design/wrp_pkg.sv
// Package for the waypoint reply parser: word types, command, event and
// character codes, scanner stage codes and the block's fixed limits.
// No dependencies.
`default_nettype none
package wrp_pkg;

    localparam int MAX_WAYPOINTS = 512;
    localparam int LINE_LIMIT    = 256;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_BYTE  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [1:0] EV_COUNT    = 2'd0;
    localparam logic [1:0] EV_WAYPOINT = 2'd1;
    localparam logic [1:0] EV_DONE     = 2'd2;
    localparam logic [1:0] EV_FAIL     = 2'd3;

    localparam logic [1:0] FAIL_TIMEOUT   = 2'd0;
    localparam logic [1:0] FAIL_BAD_BYTE  = 2'd1;
    localparam logic [1:0] FAIL_COUNT_BIG = 2'd2;

    localparam logic [1:0] SC_SKIP   = 2'd0;
    localparam logic [1:0] SC_SIGN   = 2'd1;
    localparam logic [1:0] SC_DIGITS = 2'd2;
    localparam logic [1:0] SC_DONE   = 2'd3;

    localparam logic [7:0] CH_N     = 8'h4E;
    localparam logic [7:0] CH_W     = 8'h57;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [13:0] REPLY_TIMEOUT_RESET = 14'd10000;
    localparam logic [13:0] CHAR_TIMEOUT_RESET  = 14'd1000;

    localparam logic REG_REPLY_TIMEOUT = 1'b0;
    localparam logic REG_CHAR_TIMEOUT  = 1'b1;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] received_byte;
    } t_in;

    typedef struct packed {
        logic [1:0]         event_kind;
        logic [9:0]         waypoint_count;
        logic [8:0]         waypoint_index;
        logic signed [31:0] latitude;
        logic signed [31:0] longitude;
        logic [1:0]         fail_reason;
    } t_out;

    typedef struct packed {
        logic [31:0] acc;
        logic        neg;
        logic [1:0]  stage;
    } t_num;

endpackage
`default_nettype wire

// File: design/wrp_num_scan.sv
// Decimal number scanner step: folds one character into the running
// number with atol rules. Depends on wrp_pkg.
`default_nettype none
module wrp_num_scan
    import wrp_pkg::*;
(
    input  t_num       i_num,
    input  logic [7:0] i_char,
    output t_num       o_num
);

    logic       is_digit;
    logic       is_space;
    logic       is_sign;
    logic [3:0] digit_val;
    logic [7:0] digit_wide;

    assign is_digit   = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign is_space   = (i_char == CH_SPACE) || (i_char == CH_TAB) ||
                        (i_char == CH_VT) || (i_char == CH_FF);
    assign is_sign    = (i_char == CH_PLUS) || (i_char == CH_MINUS);
    assign digit_wide = i_char - CH_ZERO;
    assign digit_val  = digit_wide[3:0];

    always_comb begin
        o_num = i_num;
        if (i_num.stage == SC_DONE) begin
            o_num = i_num;
        end else if (i_num.stage == SC_SKIP && is_space) begin
            o_num = i_num;
        end else if (i_num.stage == SC_SKIP && is_sign) begin
            o_num.neg   = (i_char == CH_MINUS);
            o_num.stage = SC_SIGN;
        end else if (is_digit) begin
            // times ten as two shifts, wrapping at 32 bits
            o_num.acc   = (i_num.acc << 3) + (i_num.acc << 1) + {28'd0, digit_val};
            o_num.stage = SC_DIGITS;
        end else begin
            o_num.stage = SC_DONE;
        end
    end

endmodule
`default_nettype wire

// File: design/waypoint_reply_parser_unit.sv
// Waypoint reply parser top level: input register, parse state machine,
// result register. Depends on wrp_pkg and wrp_num_scan.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in) carries one word per
//   command: start, received byte, or one millisecond tick. Output channel
//   (o_out_valid / i_out_stall / o_out) carries count, waypoint, done and
//   failed events; most words cause no event.
//   Configuration channel (i_cfg_valid / o_cfg_ready) writes the reply and
//   character timeouts; it is always ready. The user must use it only while
//   idle; the block does not enforce this. An accepted word's event is
//   registered and presented on o_out. Throughput: one word per cycle
//   while no result is held under i_out_stall; the parse of one word is a
//   single pass through the state update and the times-ten accumulator.
//   Stall: while a result is held under i_out_stall the input register
//   holds its word and o_in_stall rises once that register is full.
//   Reset: synchronous, active low; the parser goes idle, both timeouts
//   return to 10000 and 1000 ticks, and no event is pending.
`default_nettype none
module waypoint_reply_parser_unit
    import wrp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [13:0] i_cfg_data
);

    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_WAIT_N     = 3'd1;
    localparam logic [2:0] PH_COUNT_LINE = 3'd2;
    localparam logic [2:0] PH_WAIT_W     = 3'd3;
    localparam logic [2:0] PH_WAY_LINE   = 3'd4;
    localparam logic [2:0] PH_WAIT_E     = 3'd5;

    localparam logic [7:0]  POS_LAST  = 8'(LINE_LIMIT - 1);
    localparam logic [31:0] COUNT_MAX = 32'(MAX_WAYPOINTS);
    localparam logic [13:0] TICK_SAT  = 14'h3FFF;

    // pipeline registers
    logic        r_in_valid;
    t_in         r_in;
    logic        r_out_valid;
    t_out        r_out;

    // configuration
    logic [13:0] r_reply_to;
    logic [13:0] r_char_to;

    // parse state
    logic [2:0]  r_phase,    n_phase;
    logic [13:0] r_tick,     n_tick;
    logic [7:0]  r_pos,      n_pos;
    t_num        r_num,      n_num;
    logic        r_second,   n_second;
    logic [31:0] r_held,     n_held;
    logic [9:0]  r_exp_cnt,  n_exp_cnt;
    logic [9:0]  r_next_idx, n_next_idx;
    logic        n_res_valid;
    t_out        n_out;

    logic        advance;
    logic        take;
    t_num        num_fed;
    t_num        num_clear;
    logic [31:0] num_val;
    logic [9:0]  idx_inc;
    logic [13:0] tick_inc;
    logic [13:0] limit;
    logic        in_line;
    logic [7:0]  ch;

    assign advance     = !(r_out_valid && i_out_stall);
    assign take        = r_in_valid && advance;
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    assign ch        = r_in.received_byte;
    assign num_clear = '{acc: 32'd0, neg: 1'b0, stage: SC_SKIP};
    assign num_val   = r_num.neg ? (32'd0 - r_num.acc) : r_num.acc;
    assign idx_inc   = r_next_idx + 10'd1;
    assign in_line   = (r_phase == PH_COUNT_LINE) || (r_phase == PH_WAY_LINE);
    assign limit     = in_line ? r_char_to : r_reply_to;
    assign tick_inc  = (r_tick != TICK_SAT) ? (r_tick + 14'd1) : r_tick;

    wrp_num_scan u_num_scan (
        .i_num  (r_num),
        .i_char (ch),
        .o_num  (num_fed)
    );

    always_comb begin
        n_phase     = r_phase;
        n_tick      = r_tick;
        n_pos       = r_pos;
        n_num       = r_num;
        n_second    = r_second;
        n_held      = r_held;
        n_exp_cnt   = r_exp_cnt;
        n_next_idx  = r_next_idx;
        n_res_valid = 1'b0;
        n_out       = '0;

        if (r_in.command == CMD_START) begin
            n_phase    = PH_WAIT_N;
            n_tick     = 14'd0;
            n_exp_cnt  = 10'd0;
            n_next_idx = 10'd0;
            n_pos      = 8'd0;
            n_second   = 1'b0;
            n_held     = 32'd0;
            n_num      = num_clear;
        end else if (r_phase == PH_IDLE || r_phase > PH_WAIT_E) begin
            // drop bytes and ticks while idle
        end else if (r_in.command == CMD_TICK) begin
            n_tick = tick_inc;
            if (tick_inc >= limit) begin
                n_phase           = PH_IDLE;
                n_tick            = 14'd0;
                n_res_valid       = 1'b1;
                n_out.event_kind  = EV_FAIL;
                n_out.fail_reason = FAIL_TIMEOUT;
            end
        end else if (r_in.command == CMD_BYTE) begin
            n_tick = 14'd0;
            case (r_phase)
                PH_WAIT_N, PH_WAIT_W: begin
                    if ((r_phase == PH_WAIT_N && ch != CH_N) ||
                        (r_phase == PH_WAIT_W && ch != CH_W)) begin
                        n_phase           = PH_IDLE;
                        n_res_valid       = 1'b1;
                        n_out.event_kind  = EV_FAIL;
                        n_out.fail_reason = FAIL_BAD_BYTE;
                    end else begin
                        n_phase  = (r_phase == PH_WAIT_N) ? PH_COUNT_LINE : PH_WAY_LINE;
                        n_pos    = 8'd0;
                        n_second = 1'b0;
                        n_held   = 32'd0;
                        n_num    = num_clear;
                    end
                end
                PH_WAIT_E: begin
                    n_phase     = PH_IDLE;
                    n_res_valid = 1'b1;
                    if (ch != CH_E) begin
                        n_out.event_kind  = EV_FAIL;
                        n_out.fail_reason = FAIL_BAD_BYTE;
                    end else begin
                        n_out.event_kind = EV_DONE;
                    end
                end
                default: begin
                    if (ch == CH_LF || ch == CH_CR) begin
                        n_res_valid = 1'b1;
                        if (r_phase == PH_COUNT_LINE) begin
                            if (!num_val[31] && num_val > COUNT_MAX) begin
                                n_phase           = PH_IDLE;
                                n_out.event_kind  = EV_FAIL;
                                n_out.fail_reason = FAIL_COUNT_BIG;
                            end else begin
                                // a negative count reads as zero
                                n_exp_cnt            = num_val[31] ? 10'd0 : num_val[9:0];
                                n_next_idx           = 10'd0;
                                n_phase              = (n_exp_cnt == 10'd0) ? PH_WAIT_E
                                                                            : PH_WAIT_W;
                                n_out.event_kind     = EV_COUNT;
                                n_out.waypoint_count = n_exp_cnt;
                            end
                        end else begin
                            n_out.event_kind     = EV_WAYPOINT;
                            n_out.waypoint_index = r_next_idx[8:0];
                            n_out.latitude       = r_second ? r_held : num_val;
                            n_out.longitude      = r_second ? num_val : 32'd0;
                            n_next_idx           = idx_inc;
                            n_phase              = (idx_inc >= r_exp_cnt) ? PH_WAIT_E
                                                                          : PH_WAIT_W;
                        end
                    end else if (r_pos < POS_LAST) begin
                        // the first kept byte of a line is dropped
                        if (r_pos != 8'd0) begin
                            if (r_phase == PH_WAY_LINE && !r_second && ch == CH_SPACE) begin
                                n_held   = num_val;
                                n_second = 1'b1;
                                n_num    = num_clear;
                            end else begin
                                n_num = num_fed;
                            end
                        end
                        n_pos = r_pos + 8'd1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_reply_to  <= REPLY_TIMEOUT_RESET;
            r_char_to   <= CHAR_TIMEOUT_RESET;
            r_phase     <= PH_IDLE;
            r_tick      <= 14'd0;
            r_pos       <= 8'd0;
            r_num       <= '{acc: 32'd0, neg: 1'b0, stage: SC_SKIP};
            r_second    <= 1'b0;
            r_held      <= 32'd0;
            r_exp_cnt   <= 10'd0;
            r_next_idx  <= 10'd0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_REPLY_TIMEOUT) begin
                    r_reply_to <= i_cfg_data;
                end else if (i_cfg_index == REG_CHAR_TIMEOUT) begin
                    r_char_to <= i_cfg_data;
                end
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= take && n_res_valid;
            end
            if (take) begin
                r_phase    <= n_phase;
                r_tick     <= n_tick;
                r_pos      <= n_pos;
                r_num      <= n_num;
                r_second   <= n_second;
                r_held     <= n_held;
                r_exp_cnt  <= n_exp_cnt;
                r_next_idx <= n_next_idx;
            end
        end
    end

    // payload registers: load without reset
    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in;
        end
        if (take && n_res_valid) begin
            r_out <= n_out;
        end
    end

    a_end_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && n_res_valid && (n_out.event_kind == EV_FAIL || n_out.event_kind == EV_DONE)
        |=> r_phase == PH_IDLE)
        else $error("phase not idle after done or failed event");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid && i_out_stall)
        else $error("input stalled without a held result");

    a_index_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take && n_res_valid && n_out.event_kind == EV_WAYPOINT
        |=> r_next_idx <= r_exp_cnt)
        else $error("waypoint index ran past announced count");

endmodule
`default_nettype wire

// File: test/tb.sv
`timescale 1ns / 1ps
// Testbench for waypoint_reply_parser_unit: random start, byte and tick words
// through a stall handshake, with events checked against an in-bench parser.
// Depends on wrp_pkg and the design sources.
module tb
    import wrp_pkg::*;
();

    localparam logic [1:0] CMD_NONE      = 2'd3;
    localparam int         SETTLE_CYCLES = 10;
    localparam int         QUIET_LIMIT   = 2000;
    localparam int         PHASE_WORDS   = 60;

    typedef enum logic [2:0] {
        PH_IDLE, PH_WAIT_N, PH_COUNT_LINE, PH_WAIT_W, PH_WAY_LINE, PH_WAIT_E
    } t_phase;

    typedef struct packed {
        t_in  word;
        logic calm;
    } t_feed;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in         i_in        = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out        o_out;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [13:0] i_cfg_data  = '0;

    waypoint_reply_parser_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out      (o_out),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Parser state as seen from the host side of the link.
    logic [13:0] reply_limit;
    logic [13:0] char_limit;
    t_phase      ph;
    logic [13:0] ticks;
    logic [7:0]  line_pos;
    logic [31:0] num_acc;
    logic        num_neg;
    logic [1:0]  num_stage;
    logic        second_field;
    logic [31:0] held_lat;
    logic [9:0]  want_count;
    logic [9:0]  next_index;

    t_feed word_feed[$];
    t_out  awaited_events[$];
    logic  calm_now = 1'b0;
    int    words_queued = 0;
    int    mismatches = 0;

    // driver state
    t_feed cur_word  = '0;
    logic  in_busy   = 1'b0;
    int    send_gap  = 0;
    logic  out_calm  = 1'b0;
    t_out  predicted;

    function automatic void clear_number();
        num_acc   = '0;
        num_neg   = 1'b0;
        num_stage = SC_SKIP;
    endfunction

    function automatic void begin_line();
        line_pos     = '0;
        second_field = 1'b0;
        held_lat     = '0;
        clear_number();
    endfunction

    function automatic bit fail_exchange(input logic [1:0] reason, output t_out ev);
        ph             = PH_IDLE;
        ticks          = '0;
        ev             = '0;
        ev.event_kind  = EV_FAIL;
        ev.fail_reason = reason;
        return 1'b1;
    endfunction

    // Advance the parser by one word; return 1 when it raises an event.
    function automatic bit parse_word(input t_in w, output t_out ev);
        logic [31:0] val;
        logic [13:0] limit;
        logic [7:0]  c;
        c   = w.received_byte;
        ev  = '0;
        val = num_neg ? 32'd0 - num_acc : num_acc;
        if (w.command == CMD_START) begin
            ph         = PH_WAIT_N;
            ticks      = '0;
            want_count = '0;
            next_index = '0;
            begin_line();
            return 1'b0;
        end
        if (ph == PH_IDLE || w.command == CMD_NONE)
            return 1'b0;
        if (w.command == CMD_TICK) begin
            limit = (ph == PH_COUNT_LINE || ph == PH_WAY_LINE) ? char_limit : reply_limit;
            if (ticks != 14'h3FFF)
                ticks++;
            if (ticks >= limit)
                return fail_exchange(FAIL_TIMEOUT, ev);
            return 1'b0;
        end
        ticks = '0;
        case (ph)
            PH_WAIT_N: begin
                if (c != CH_N)
                    return fail_exchange(FAIL_BAD_BYTE, ev);
                begin_line();
                ph = PH_COUNT_LINE;
                return 1'b0;
            end
            PH_WAIT_W: begin
                if (c != CH_W)
                    return fail_exchange(FAIL_BAD_BYTE, ev);
                begin_line();
                ph = PH_WAY_LINE;
                return 1'b0;
            end
            PH_WAIT_E: begin
                if (c != CH_E)
                    return fail_exchange(FAIL_BAD_BYTE, ev);
                ph            = PH_IDLE;
                ev.event_kind = EV_DONE;
                return 1'b1;
            end
            default: ;
        endcase
        if (c == CH_LF || c == CH_CR) begin
            if (ph == PH_COUNT_LINE) begin
                // a negative count reads as zero
                if (!val[31] && val > MAX_WAYPOINTS)
                    return fail_exchange(FAIL_COUNT_BIG, ev);
                want_count        = val[31] ? 10'd0 : val[9:0];
                next_index        = '0;
                ev.event_kind     = EV_COUNT;
                ev.waypoint_count = want_count;
                if (want_count == 0)
                    ph = PH_WAIT_E;
                else
                    ph = PH_WAIT_W;
            end else begin
                ev.event_kind     = EV_WAYPOINT;
                ev.waypoint_index = next_index[8:0];
                ev.latitude       = second_field ? held_lat : val;
                ev.longitude      = second_field ? val : 32'd0;
                next_index++;
                if (next_index >= want_count)
                    ph = PH_WAIT_E;
                else
                    ph = PH_WAIT_W;
            end
            return 1'b1;
        end
        // bytes at or past the last line position only restart the character timer
        if (line_pos >= LINE_LIMIT - 1)
            return 1'b0;
        if (line_pos != 0) begin
            if (ph == PH_WAY_LINE && !second_field && c == CH_SPACE) begin
                held_lat     = val;
                second_field = 1'b1;
                clear_number();
            end else if (num_stage != SC_DONE) begin
                if (num_stage == SC_SKIP &&
                    (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF)) begin
                end else if (num_stage == SC_SKIP && (c == CH_PLUS || c == CH_MINUS)) begin
                    num_neg   = (c == CH_MINUS);
                    num_stage = SC_SIGN;
                end else if (c >= CH_ZERO && c <= CH_NINE) begin
                    num_acc   = num_acc * 10 + 32'(c - CH_ZERO);
                    num_stage = SC_DIGITS;
                end else begin
                    num_stage = SC_DONE;
                end
            end
        end
        line_pos++;
        return 1'b0;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic void put(input logic [1:0] cmd, input logic [7:0] b);
        t_feed f;
        f.word.command       = cmd;
        f.word.received_byte = b;
        f.calm               = calm_now;
        word_feed.push_back(f);
        words_queued++;
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        put(CMD_BYTE, b);
    endfunction

    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == CH_LF || b == CH_CR);
        return b;
    endfunction

    // first byte of a line, dropped by the parser
    function automatic logic [7:0] lead_byte();
        return ($urandom_range(0, 3) != 0) ? CH_SPACE : junk_byte();
    endfunction

    function automatic void put_line_end();
        put_byte($urandom_range(0, 1) ? CH_CR : CH_LF);
    endfunction

    function automatic void put_decimal(input longint unsigned v);
        logic [7:0] digits[$];
        do begin
            digits.push_front(8'(CH_ZERO + v % 10));
            v = v / 10;
        end while (v != 0);
        foreach (digits[k])
            put_byte(digits[k]);
    endfunction

    // free-form number text: blanks, sign, digits, sometimes trailing junk
    function automatic void put_number(input bit space_ok);
        logic [7:0] ws;
        int         n_ws;
        int         n_dig;
        n_ws  = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
        n_dig = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 12) : $urandom_range(1, 4);
        repeat (n_ws) begin
            case ($urandom_range(0, 3))
                0:       ws = CH_TAB;
                1:       ws = CH_VT;
                2:       ws = CH_FF;
                default: ws = space_ok ? CH_SPACE : CH_TAB;
            endcase
            put_byte(ws);
        end
        case ($urandom_range(0, 3))
            0:       put_byte(CH_PLUS);
            1:       put_byte(CH_MINUS);
            default: ;
        endcase
        repeat (n_dig)
            put_byte(8'(CH_ZERO + $urandom_range(0, 9)));
        if ($urandom_range(0, 5) == 0)
            put_byte(junk_byte());
    endfunction

    function automatic void tick_burst();
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 6)) put(CMD_TICK, 8'($urandom));
        if ($urandom_range(0, 40) == 0)
            repeat (45) put(CMD_TICK, 8'($urandom));
    endfunction

    // One reply, mostly well formed, with random numbers and ticks.
    function automatic void gen_exchange();
        int cnt;
        calm_now = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 15) == 0)
            repeat ($urandom_range(1, 4))
                put(2'($urandom_range(1, 3)), 8'($urandom));
        put(CMD_START, 8'($urandom));
        tick_burst();
        put_byte(($urandom_range(0, 24) == 0) ? junk_byte() : CH_N);
        tick_burst();
        put_byte(lead_byte());
        cnt = $urandom_range(0, 4);
        case ($urandom_range(0, 19))
            15: begin
                put_decimal(MAX_WAYPOINTS);
                cnt = $urandom_range(0, 2);
            end
            16: put_decimal(MAX_WAYPOINTS + 1 + $urandom_range(0, 100000));
            17: begin
                put_byte(CH_MINUS);
                put_decimal(1 + $urandom_range(0, 999));
                cnt = 0;
            end
            18: put_decimal(64'd4294967296 + cnt);
            19: begin
                put_number(1'b1);
                cnt = $urandom_range(0, 3);
            end
            default: begin
                if ($urandom_range(0, 3) == 0)
                    put_byte(CH_PLUS);
                // a zero count sometimes comes as a blank line
                if (cnt != 0 || $urandom_range(0, 3) != 0)
                    put_decimal(cnt);
            end
        endcase
        tick_burst();
        put_line_end();
        for (int i = 0; i < cnt; i++) begin
            tick_burst();
            put_byte(($urandom_range(0, 24) == 0) ? junk_byte() : CH_W);
            if ($urandom_range(0, 15) != 0)
                put_byte(lead_byte());
            put_number(1'b0);
            if ($urandom_range(0, 9) != 0) begin
                put_byte(CH_SPACE);
                put_number(1'b1);
            end
            tick_burst();
            put_line_end();
        end
        tick_burst();
        // leave the reply open now and then so the next start restarts it
        if ($urandom_range(0, 19) != 0)
            put_byte(($urandom_range(0, 24) == 0) ? junk_byte() : CH_E);
    endfunction

    task automatic drain_parser();
        while (word_feed.size() != 0 || in_busy || awaited_events.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [13:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == REG_REPLY_TIMEOUT)
            reply_limit = val;
        else
            char_limit = val;
    endtask

    initial begin
        logic [13:0] r_to;
        logic [13:0] c_to;
        reply_limit = REPLY_TIMEOUT_RESET;
        char_limit  = CHAR_TIMEOUT_RESET;
        ph          = PH_IDLE;
        ticks       = '0;
        want_count  = '0;
        next_index  = '0;
        begin_line();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // idle words are ignored
        put(CMD_TICK, 8'hFF);
        put_byte(8'h00);
        put(CMD_NONE, 8'hFF);
        // count 2 with a junk lead byte, then signed lat/lon, then no lon
        put(CMD_START, 8'h00);
        put_byte(CH_N);
        put_byte(8'hFF);
        put_decimal(2);
        put_byte(CH_LF);
        put_byte(CH_W);
        put_byte(CH_SPACE);
        put_byte(CH_MINUS);
        put_decimal(5);
        put_byte(CH_SPACE);
        put_byte(CH_PLUS);
        put_decimal(7);
        put_byte(CH_CR);
        put_byte(CH_W);
        put_byte(CH_SPACE);
        put_decimal(9);
        put_byte(CH_LF);
        put_byte(CH_E);
        // wrong leading byte
        put(CMD_START, 8'h00);
        put(CMD_TICK, 8'h00);
        put_byte(8'h51);

        for (int p = 0; p < 9; p++) begin
            if (p != 0) begin
                // force idle, wait out every event, then retune the timeouts
                calm_now = 1'b0;
                put(CMD_START, 8'h00);
                put_byte(8'h00);
                drain_parser();
                case (p)
                    1:       begin r_to = 14'd16383; c_to = 14'd16383; end
                    2:       begin r_to = 14'd1;     c_to = 14'd1;     end
                    3:       begin r_to = 14'd1;     c_to = 14'd16383; end
                    4:       begin r_to = 14'd16383; c_to = 14'd1;     end
                    default: begin
                        r_to = 14'($urandom_range(2, 40));
                        c_to = 14'($urandom_range(2, 20));
                    end
                endcase
                write_reg(REG_REPLY_TIMEOUT, r_to);
                write_reg(REG_CHAR_TIMEOUT, c_to);
            end
            if (p == 1) begin
                // one waypoint line well past the line limit
                calm_now = 1'b0;
                put(CMD_START, 8'h00);
                put_byte(CH_N);
                put_byte(CH_SPACE);
                put_decimal(1);
                put_byte(CH_LF);
                put_byte(CH_W);
                put_byte(CH_SPACE);
                repeat (300)
                    put_byte(($urandom_range(0, 10) == 0) ? CH_SPACE :
                             8'(CH_ZERO + $urandom_range(0, 9)));
                put_byte(CH_CR);
                put_byte(CH_E);
            end
            for (int stop_at = words_queued + PHASE_WORDS; words_queued < stop_at; )
                gen_exchange();
        end

        drain_parser();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------ driver

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_busy    = 1'b0;
            send_gap   = 0;
            i_in_valid <= 1'b0;
        end else begin
            if (in_busy && !o_in_stall) begin
                if (parse_word(cur_word.word, predicted))
                    awaited_events.push_back(predicted);
                send_gap = cur_word.calm ? 0 : $urandom_range(0, 5);
                out_calm <= cur_word.calm;
                in_busy  = 1'b0;
            end
            if (!in_busy) begin
                if (send_gap > 0)
                    send_gap--;
                else if (word_feed.size() != 0) begin
                    cur_word = word_feed.pop_front();
                    in_busy  = 1'b1;
                end
            end
            i_in_valid <= in_busy;
            i_in       <= cur_word.word;
        end
    end

    // ----------------------------------------------------------------- monitor

    function automatic void report(input string what, input t_out want, input t_out got);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: expected kind %0d count %0d index %0d lat %0d lon %0d reason %0d,",
                     what, want.event_kind, want.waypoint_count, want.waypoint_index,
                     want.latitude, want.longitude, want.fail_reason,
                     " got kind %0d count %0d index %0d lat %0d lon %0d reason %0d",
                     got.event_kind, got.waypoint_count, got.waypoint_index,
                     got.latitude, got.longitude, got.fail_reason);
    endfunction

    t_out want_event;
    int   hold_cnt = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (awaited_events.size() == 0) begin
                    report("unexpected event", '0, o_out);
                end else begin
                    want_event = awaited_events.pop_front();
                    if (o_out.event_kind     !== want_event.event_kind     ||
                        o_out.waypoint_count !== want_event.waypoint_count ||
                        o_out.waypoint_index !== want_event.waypoint_index ||
                        o_out.latitude       !== want_event.latitude       ||
                        o_out.longitude      !== want_event.longitude      ||
                        o_out.fail_reason    !== want_event.fail_reason)
                        report("event mismatch", want_event, o_out);
                end
                hold_cnt = out_calm ? 0 : $urandom_range(0, 5);
            end else if (hold_cnt > 0) begin
                hold_cnt--;
            end
            i_out_stall <= (hold_cnt != 0);
        end
    end

    // ---------------------------------------------------------------- watchdog

    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

endmodule
